FILE: sv/frns_pkg.sv
// Shared types and constants for the fixed-radius neighbour search block.
// No dependencies; imported by fixed_radius_neighbor_search_top.
`timescale 1ns / 1ps
`default_nettype none

package frns_pkg;

    localparam int COORD_W            = 20;
    localparam int TAG_W              = 14;
    localparam int DIST_W             = 42;
    localparam int SQ_W               = 41;   // |d| <= 2^20, so d*d <= 2^40
    localparam int MAX_CANDIDATES_DEF = 64;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } t_state;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic [TAG_W-1:0]   tag;
    } t_cand;

endpackage

`default_nettype wire

FILE: sv/fixed_radius_neighbor_search_top.sv
// Fixed-radius neighbour search: candidate store, pipelined distance unit, result sequencer.
// Depends on frns_pkg.
//
//  channel   direction  handshake                      payload
//  -------   ---------  -----------------------------  -----------------------------------------
//  command   in         start & !busy                  i_op, i_coord_x/y/z, i_point_tag
//  result    out        o_result_valid (one cycle)     o_match_tag, o_found, o_last, o_store_full
//  config    in         i_cfg_valid & o_cfg_ready      i_cfg_data (squared distance limit)
//
// Clear, load and unused op codes: busy stays low, the result item appears the cycle after accept.
// Query: the stored candidates are scanned in order of loading; one candidate enters the
// distance unit (memory read, three squarers, sum and compare) each cycle.
// Reset empties the store and zeroes the limit; stored points are not cleared.
// The receiver cannot stall: each result item is shown for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none

module fixed_radius_neighbor_search_top #(
    parameter int MAX_CANDIDATES = frns_pkg::MAX_CANDIDATES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [1:0]                    i_op,
    input  wire logic signed [frns_pkg::COORD_W-1:0] i_coord_x,
    input  wire logic signed [frns_pkg::COORD_W-1:0] i_coord_y,
    input  wire logic signed [frns_pkg::COORD_W-1:0] i_coord_z,
    input  wire logic [frns_pkg::TAG_W-1:0]    i_point_tag,
    output logic                               o_result_valid,
    output logic [frns_pkg::TAG_W-1:0]         o_match_tag,
    output logic                               o_found,
    output logic                               o_last,
    output logic                               o_store_full,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [frns_pkg::DIST_W-1:0]   i_cfg_data
);
    import frns_pkg::*;

    localparam int IDX_W = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
    localparam int CNT_W = $clog2(MAX_CANDIDATES + 1);

    // state and control
    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count;
    logic [IDX_W-1:0]   r_idx;
    logic [DIST_W-1:0]  r_max_dist;
    logic               accept;
    logic               store_full_now;
    logic               last_issue;

    // query point
    logic [COORD_W-1:0] r_qx, r_qy, r_qz;

    // candidate store
    t_cand              mem [MAX_CANDIDATES];
    t_cand              r_rd;

    // distance pipeline
    logic               r_v1, r_v2, r_v3;
    logic signed [COORD_W:0]   dx, dy, dz;
    logic signed [2*COORD_W+1:0] sqx, sqy, sqz;
    logic [SQ_W-1:0]    r_sqx, r_sqy, r_sqz;
    logic [TAG_W-1:0]   r_tag2, r_tag3;
    logic [DIST_W-1:0]  dist_sum;
    logic               r_hit;

    // held match and result registers
    logic               r_pend_valid, n_pend_valid;
    logic [TAG_W-1:0]   r_pend_tag, n_pend_tag;
    logic               n_out_valid, n_out_found, n_out_last, n_out_full;
    logic [TAG_W-1:0]   n_out_tag;

    assign busy           = (r_state != ST_IDLE);
    assign o_cfg_ready    = (r_state == ST_IDLE);
    assign accept         = start && !busy;
    assign store_full_now = (r_count >= CNT_W'(MAX_CANDIDATES));
    assign last_issue     = ((CNT_W'(r_idx) + CNT_W'(1)) == r_count);

    // limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_dist <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_max_dist <= i_cfg_data;
        end
    end

    // candidate store: one write port for loads, one registered read port for the scan
    always_ff @(posedge i_clk) begin
        if (accept && i_op == OP_LOAD && !store_full_now) begin
            mem[r_count[IDX_W-1:0]] <= '{x: i_coord_x, y: i_coord_y, z: i_coord_z,
                                         tag: i_point_tag};
        end
        r_rd <= mem[r_idx];
    end

    // distance unit, stage 1: differences and squares
    always_comb begin
        dx  = $signed({r_qx[COORD_W-1], r_qx}) - $signed({r_rd.x[COORD_W-1], r_rd.x});
        dy  = $signed({r_qy[COORD_W-1], r_qy}) - $signed({r_rd.y[COORD_W-1], r_rd.y});
        dz  = $signed({r_qz[COORD_W-1], r_qz}) - $signed({r_rd.z[COORD_W-1], r_rd.z});
        sqx = dx * dx;
        sqy = dy * dy;
        sqz = dz * dz;
    end

    // stage 2: sum of squares, compared with the limit (inclusive)
    assign dist_sum = DIST_W'(r_sqx) + DIST_W'(r_sqy) + DIST_W'(r_sqz);

    always_ff @(posedge i_clk) begin
        r_sqx  <= sqx[SQ_W-1:0];
        r_sqy  <= sqy[SQ_W-1:0];
        r_sqz  <= sqz[SQ_W-1:0];
        r_tag2 <= r_rd.tag;
        r_hit  <= (dist_sum <= r_max_dist);
        r_tag3 <= r_tag2;
        if (accept && i_op == OP_QUERY) begin
            r_qx <= i_coord_x;
            r_qy <= i_coord_y;
            r_qz <= i_coord_z;
        end
        r_pend_tag <= n_pend_tag;
    end

    // state register and control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_count        <= '0;
            r_idx          <= '0;
            r_v1           <= 1'b0;
            r_v2           <= 1'b0;
            r_v3           <= 1'b0;
            r_pend_valid   <= 1'b0;
            o_result_valid <= 1'b0;
            o_match_tag    <= '0;
            o_found        <= 1'b0;
            o_last         <= 1'b0;
            o_store_full   <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_v1           <= (r_state == ST_SCAN);
            r_v2           <= r_v1;
            r_v3           <= r_v2;
            r_pend_valid   <= n_pend_valid;
            o_result_valid <= n_out_valid;
            o_match_tag    <= n_out_tag;
            o_found        <= n_out_found;
            o_last         <= n_out_last;
            o_store_full   <= n_out_full;
            if (accept && i_op == OP_CLEAR) begin
                r_count <= '0;
            end else if (accept && i_op == OP_LOAD && !store_full_now) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (accept) begin
                r_idx <= '0;
            end else if (r_state == ST_SCAN) begin
                r_idx <= r_idx + IDX_W'(1);
            end
        end
    end

    // next state and results
    always_comb begin
        n_state      = r_state;
        n_pend_valid = r_pend_valid;
        n_pend_tag   = r_pend_tag;
        n_out_valid  = 1'b0;
        n_out_tag    = '0;
        n_out_found  = 1'b0;
        n_out_last   = 1'b0;
        n_out_full   = 1'b0;

        // hold each match until the next one shows it was not the last
        if (r_v3 && r_hit) begin
            if (r_pend_valid) begin
                n_out_valid = 1'b1;
                n_out_tag   = r_pend_tag;
                n_out_found = 1'b1;
            end
            n_pend_valid = 1'b1;
            n_pend_tag   = r_tag3;
        end

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_pend_valid = 1'b0;
                    case (i_op)
                        OP_LOAD: begin
                            n_out_valid = 1'b1;
                            n_out_last  = 1'b1;
                            n_out_full  = store_full_now;
                        end
                        OP_QUERY: begin
                            if (r_count == '0) begin
                                n_out_valid = 1'b1;
                                n_out_last  = 1'b1;
                            end else begin
                                n_state = ST_SCAN;
                            end
                        end
                        default: begin
                            n_out_valid = 1'b1;
                            n_out_last  = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (last_issue) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // pipeline empty: flush the held match as last, or report no match
                if (!r_v1 && !r_v2 && !r_v3) begin
                    n_out_valid  = 1'b1;
                    n_out_last   = 1'b1;
                    n_out_found  = r_pend_valid;
                    n_out_tag    = r_pend_valid ? r_pend_tag : '0;
                    n_pend_valid = 1'b0;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    a_nomatch_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && !o_found |-> o_last)
        else $error("result without a match not marked last");

    a_full_only_on_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_store_full |-> !o_found && o_last && !busy)
        else $error("store full flag on a query result");

    a_pipe_only_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 || r_v2 || r_v3) |-> busy)
        else $error("distance pipeline active while idle");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_CANDIDATES))
        else $error("candidate count beyond store depth");

endmodule

`default_nettype wire
